// ===== hw/rtl/mse_pkg.sv =====
// Shared types, codes and constants for the execute unit.
// No dependencies; every other RTL file except mse_ram imports this package.
`default_nettype none

package mse_pkg;

    localparam int unsigned MemWordsDefault   = 65536;
    localparam int unsigned QueueDepthDefault = 2;

    localparam int unsigned DataW = 32;
    localparam int unsigned PcW   = 19;
    localparam int unsigned RegAW = 5;
    localparam int unsigned TgtW  = 18;
    localparam int unsigned ErrW  = 3;
    localparam int unsigned NumRegs = 32;

    localparam logic [RegAW-1:0] RegZero = 5'd0;
    localparam logic [RegAW-1:0] RegSp   = 5'd29;
    localparam logic [DataW-1:0] SpReset = 32'd262140;

    // Instruction function codes as they arrive on the input stream.
    localparam logic [3:0] FUNC_ADD  = 4'd0;
    localparam logic [3:0] FUNC_SUB  = 4'd1;
    localparam logic [3:0] FUNC_MUL  = 4'd2;
    localparam logic [3:0] FUNC_BEQ  = 4'd3;
    localparam logic [3:0] FUNC_BNE  = 4'd4;
    localparam logic [3:0] FUNC_SLT  = 4'd5;
    localparam logic [3:0] FUNC_ADDI = 4'd6;
    localparam logic [3:0] FUNC_LW   = 4'd7;
    localparam logic [3:0] FUNC_SW   = 4'd8;
    localparam logic [3:0] FUNC_J    = 4'd9;

    // Error codes of a result word.
    localparam logic [ErrW-1:0] ERR_NONE   = 3'd0;
    localparam logic [ErrW-1:0] ERR_AREA   = 3'd1;
    localparam logic [ErrW-1:0] ERR_ALIGN  = 3'd2;
    localparam logic [ErrW-1:0] ERR_BEYOND = 3'd3;
    localparam logic [ErrW-1:0] ERR_LABEL  = 3'd4;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_BEQ, OP_BNE, OP_SLT,
        OP_ADDI, OP_LW, OP_SW, OP_J, OP_NOP
    } t_op;

    // Classified instruction as it travels through the queue.
    typedef struct packed {
        t_op              op;
        logic [RegAW-1:0] rd;
        logic [RegAW-1:0] ra;
        logic [RegAW-1:0] rb_port;  // rb, or rd for a store's data
        logic [DataW-1:0] imm;
        logic             mul_imm;
        logic             has_base;
        logic [TgtW-1:0]  target;
        logic             known;
    } t_item;

    function automatic logic [DataW-1:0] rf_reset_value(input logic [RegAW-1:0] idx);
        rf_reset_value = (idx == RegSp) ? SpReset : '0;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mse_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none

module mse_ram #(
    parameter int unsigned W     = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mse_front.sv =====
// Front end: accept instruction words and classify them for the queue.
// Depends on mse_pkg.
`default_nettype none

module mse_front import mse_pkg::*; (
    input  wire logic        i_tvalid,
    output      logic        o_tready,
    input  wire logic [71:0] i_tdata,
    input  wire logic [3:0]  i_tuser,
    input  wire logic        i_enable,
    input  wire logic        i_q_full,
    output      logic        o_push,
    output      t_item       o_item
);

    t_op op;

    always_comb begin
        unique case (i_tuser)
            FUNC_ADD:  op = OP_ADD;
            FUNC_SUB:  op = OP_SUB;
            FUNC_MUL:  op = OP_MUL;
            FUNC_BEQ:  op = OP_BEQ;
            FUNC_BNE:  op = OP_BNE;
            FUNC_SLT:  op = OP_SLT;
            FUNC_ADDI: op = OP_ADDI;
            FUNC_LW:   op = OP_LW;
            FUNC_SW:   op = OP_SW;
            FUNC_J:    op = OP_J;
            default:   op = OP_NOP;  // nop and unused codes
        endcase
    end

    always_comb begin
        o_item.op       = op;
        o_item.rd       = i_tdata[4:0];
        o_item.ra       = i_tdata[9:5];
        // a store reads its data register on the second port
        o_item.rb_port  = (op == OP_SW) ? i_tdata[4:0] : i_tdata[14:10];
        o_item.imm      = i_tdata[46:15];
        o_item.mul_imm  = i_tdata[47];
        o_item.has_base = i_tdata[48];
        o_item.target   = i_tdata[66:49];
        o_item.known    = i_tdata[67];
    end

    assign o_tready = i_enable & ~i_q_full;
    assign o_push   = i_tvalid & o_tready;

endmodule

`default_nettype wire

// ===== hw/rtl/mse_fifo.sv =====
// Short queue of classified instructions between front and back ends.
// Depends on mse_pkg.
`default_nettype none

module mse_fifo import mse_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepthDefault,
    localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output      logic  o_full,
    input  wire logic  i_pop,
    output      logic  o_valid,
    output      t_item o_item
);

    localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
    localparam logic [CW-1:0] Full    = CW'(DEPTH);

    t_item           r_store [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == Full);
    assign o_valid = (r_count != '0);
    assign o_item  = r_store[r_rd_ptr];

endmodule

`default_nettype wire

// ===== hw/rtl/mse_back.sv =====
// Back end: register file, data memory, program counter and result register.
// Depends on mse_pkg and mse_ram.
`default_nettype none

module mse_back import mse_pkg::*; #(
    parameter int unsigned MEM_WORDS = MemWordsDefault,
    localparam int unsigned AW       = $clog2(MEM_WORDS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [PcW-1:0]   i_instr_area,
    input  wire logic             i_q_valid,
    input  wire t_item            i_q_item,
    output      logic             o_q_pop,
    output      logic             o_running,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      logic [PcW-1:0]   o_next_pc,
    output      logic [ErrW-1:0]  o_error_code,
    output      logic             o_reg_written,
    output      logic [RegAW-1:0] o_written_reg,
    output      logic [DataW-1:0] o_written_value,
    output      logic             o_finished
);

    localparam logic [AW-1:0]    LastAddr = AW'(MEM_WORDS - 1);
    localparam logic [DataW-1:0] MemBytes = DataW'(MEM_WORDS * 4);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_READ  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_LOAD  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [PcW-1:0]      r_pc, n_pc;
    logic [NumRegs-1:0]  r_rf_valid;
    t_item               r_item;
    logic                r_out_valid;
    logic [PcW-1:0]      r_pend_pc;

    logic [DataW-1:0] rf_a_rdata, rf_b_rdata, dm_rdata;
    logic [DataW-1:0] va, vb;
    logic             rf_re;
    logic             rf_we;
    logic [RegAW-1:0] rf_waddr;
    logic [DataW-1:0] rf_wdata;
    logic             dm_we, dm_re;
    logic [AW-1:0]    dm_waddr;
    logic [DataW-1:0] dm_wdata;

    logic             out_free;
    logic [DataW-1:0] opb, prod, addr;
    logic [ErrW-1:0]  mem_err;
    logic [PcW-1:0]   pc_plus4, target_pc;
    logic             take;
    logic [PcW-1:0]   ex_pc;
    logic [ErrW-1:0]  ex_err;
    logic             ex_wr;
    logic [DataW-1:0] ex_val;
    logic             load_go;
    logic             ex_done, ld_done;

    // Two copies of the register file give two read ports.
    mse_ram #(.W(DataW), .DEPTH(NumRegs)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (i_q_item.ra),
        .o_rdata (rf_a_rdata)
    );

    mse_ram #(.W(DataW), .DEPTH(NumRegs)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (i_q_item.rb_port),
        .o_rdata (rf_b_rdata)
    );

    mse_ram #(.W(DataW), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (addr[AW+1:2]),
        .o_rdata (dm_rdata)
    );

    // Never-written registers read as their reset value.
    assign va = r_rf_valid[r_item.ra]      ? rf_a_rdata : rf_reset_value(r_item.ra);
    assign vb = r_rf_valid[r_item.rb_port] ? rf_b_rdata : rf_reset_value(r_item.rb_port);

    assign out_free = ~r_out_valid | i_ready;
    assign rf_re    = (r_state == S_READ) & i_q_valid;
    assign o_q_pop  = rf_re;

    always_comb begin
        opb      = r_item.mul_imm ? r_item.imm : vb;
        prod     = va * opb;
        addr     = r_item.has_base ? va + r_item.imm : r_item.imm;
        pc_plus4 = r_pc + PcW'(4);
        target_pc = {1'b0, r_item.target};

        if (addr[DataW-1] || (addr < {{(DataW-PcW){1'b0}}, i_instr_area})) begin
            mem_err = ERR_AREA;
        end else if (addr[1:0] != 2'b00) begin
            mem_err = ERR_ALIGN;
        end else if (addr >= MemBytes) begin
            mem_err = ERR_BEYOND;
        end else begin
            mem_err = ERR_NONE;
        end

        case (r_item.op)
            OP_BEQ:  take = (va == vb);
            OP_BNE:  take = (va != vb);
            OP_J:    take = 1'b1;
            default: take = 1'b0;
        endcase

        ex_pc  = pc_plus4;
        ex_err = ERR_NONE;
        ex_wr  = 1'b0;
        ex_val = '0;
        if (take) begin
            ex_pc  = r_item.known ? target_pc : r_pc;
            ex_err = r_item.known ? ERR_NONE : ERR_LABEL;
        end
        case (r_item.op) inside
            OP_ADD:  begin ex_wr = 1'b1; ex_val = va + vb; end
            OP_SUB:  begin ex_wr = 1'b1; ex_val = va - vb; end
            OP_MUL:  begin ex_wr = 1'b1; ex_val = prod; end
            OP_SLT:  begin ex_wr = 1'b1; ex_val = DataW'($signed(va) < $signed(vb)); end
            OP_ADDI: begin ex_wr = 1'b1; ex_val = va + r_item.imm; end
            OP_LW, OP_SW: ex_err = mem_err;
            default: ;
        endcase
        // drop writes to register zero
        if (r_item.rd == RegZero) begin
            ex_wr = 1'b0;
        end
    end

    assign load_go = (r_state == S_EXEC) & (r_item.op == OP_LW) & (mem_err == ERR_NONE);
    assign ex_done = (r_state == S_EXEC) & ~load_go & out_free;
    assign ld_done = (r_state == S_LOAD) & out_free;
    assign dm_re   = load_go;

    always_comb begin
        if (r_state == S_CLEAR) begin
            dm_we    = 1'b1;
            dm_waddr = r_clr_addr;
            dm_wdata = '0;
        end else begin
            dm_we    = ex_done & (r_item.op == OP_SW) & (mem_err == ERR_NONE);
            dm_waddr = addr[AW+1:2];
            dm_wdata = vb;
        end
        rf_waddr = r_item.rd;
        if (ld_done) begin
            rf_we    = (r_item.rd != RegZero);
            rf_wdata = dm_rdata;
        end else begin
            rf_we    = ex_done & ex_wr;
            rf_wdata = ex_val;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == LastAddr) n_state = S_READ;
            S_READ:  if (i_q_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (load_go) begin
                    n_pc    = ex_pc;
                    n_state = S_LOAD;
                end else if (out_free) begin
                    n_pc    = ex_pc;
                    n_state = S_READ;
                end
            end
            S_LOAD:  if (out_free) n_state = S_READ;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pc        <= '0;
            r_rf_valid  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (rf_we) begin
                r_rf_valid[rf_waddr] <= 1'b1;
            end
            if (ex_done || ld_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_re) begin
            r_item <= i_q_item;
        end
        if (load_go) begin
            r_pend_pc <= ex_pc;
        end
        if (ex_done) begin
            o_next_pc       <= ex_pc;
            o_error_code    <= ex_err;
            o_reg_written   <= ex_wr;
            o_written_reg   <= ex_wr ? r_item.rd : '0;
            o_written_value <= ex_wr ? ex_val : '0;
            o_finished      <= (ex_pc >= i_instr_area) || (ex_err != ERR_NONE);
        end else if (ld_done) begin
            o_next_pc       <= r_pend_pc;
            o_error_code    <= ERR_NONE;
            o_reg_written   <= (r_item.rd != RegZero);
            o_written_reg   <= r_item.rd;
            o_written_value <= (r_item.rd != RegZero) ? dm_rdata : '0;
            o_finished      <= (r_pend_pc >= i_instr_area);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_running = (r_state != S_CLEAR);

endmodule

`default_nettype wire

// ===== hw/rtl/mips_subset_execute_unit.sv =====
// Top level of the execute unit: stream ports, configuration register,
// front end, queue and back end. Depends on mse_pkg, mse_front, mse_fifo, mse_back.
`default_nettype none

// Executes one pre-decoded instruction per input word and returns one result
// word per instruction, in order. The front end classifies each accepted word
// and drops it into a small queue (QUEUE_DEPTH entries), so input is taken
// while the back end is busy or a result waits on the output. The back end
// handles one instruction at a time: a read state for the register file
// (two copies for two read ports), then an execute state that writes back and
// waits while the previous result has not been taken; a load that passes its
// address checks goes on to a load state for the registered data memory read.
// After reset the data memory is swept to zero, one word a cycle, over all
// MEM_WORDS words (65536 by default); s_axis_tready stays low during the
// sweep, while configuration writes are taken at all times. Write
// instr_area_bytes only when no instruction is in flight.
module mips_subset_execute_unit import mse_pkg::*; #(
    parameter int unsigned MEM_WORDS   = MemWordsDefault,
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // instruction words
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [4:0] dest_reg, [9:5] src_reg_a, [14:10] src_reg_b, [46:15] imm,
    // [47] mul_uses_imm, [48] has_base, [66:49] target_addr, [67] target_known
    input  wire logic [71:0] s_axis_tdata,
    // [3:0] func
    input  wire logic [3:0]  s_axis_tuser,

    // result words
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [18:0] next_pc, [21:19] error_code, [22] reg_written,
    // [27:23] written_reg, [59:28] written_value, [63:60] zero
    output      logic [63:0] m_axis_tdata,
    // finished
    output      logic        m_axis_tlast,

    // instr_area_bytes register
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [18:0] i_cfg_data
);

    logic [PcW-1:0]   r_instr_area;
    t_item            front_item, q_item;
    logic             push, q_full, q_valid, q_pop, running;
    logic [PcW-1:0]   next_pc;
    logic [ErrW-1:0]  error_code;
    logic             reg_written;
    logic [RegAW-1:0] written_reg;
    logic [DataW-1:0] written_value;

    // Configuration register: always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instr_area <= '0;
        end else if (i_cfg_valid) begin
            r_instr_area <= i_cfg_data;
        end
    end

    mse_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_enable (running),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    mse_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    mse_back #(.MEM_WORDS(MEM_WORDS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_instr_area    (r_instr_area),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .o_running       (running),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_next_pc       (next_pc),
        .o_error_code    (error_code),
        .o_reg_written   (reg_written),
        .o_written_reg   (written_reg),
        .o_written_value (written_value),
        .o_finished      (m_axis_tlast)
    );

    // Pack the result word, low field first, zero-fill to 64 bits.
    assign m_axis_tdata = {4'b0000, written_value, written_reg, reg_written,
                           error_code, next_pc};

endmodule

`default_nettype wire
